/* rtl/core/bpwm_pkg.sv */
// ----------------------------------------------------------------------------
// bpwm_pkg
// Shared types, constants and helpers for the byte loaded multichannel PWM.
// ----------------------------------------------------------------------------
package bpwm_pkg;

  // Number of PWM channels (cells in the chain), 1 to 9
  localparam int unsigned CHANNELS   = 9;
  localparam int unsigned MaxSlots   = 16;

  // Field widths
  localparam int unsigned DutyW      = 8;
  localparam int unsigned CountW     = 8;
  localparam int unsigned TimeoutW   = 8;
  localparam int unsigned ChanOnW    = 9;
  localparam int unsigned WposW      = 4;

  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd200;

  // Item opcodes
  localparam logic OpTick = 1'b0;
  localparam logic OpByte = 1'b1;

  // Duty values after reset, one per slot
  localparam logic [DutyW-1:0] DutyInit [MaxSlots] = '{
    8'h90, 8'h40, 8'hC0, 8'h40, 8'h90, 8'h40, 8'h90, 8'h40, 8'h90,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              load;       // byte item: token holder takes the byte
    logic              resync;     // timeout expired: token returns to cell 0
    logic [DutyW-1:0]  duty_byte;
    logic [CountW-1:0] count_next; // counter value after this item
  } cell_ctrl_t;

  // One-hot token vector to channel index
  function automatic logic [WposW-1:0] onehot_to_index(input logic [CHANNELS-1:0] oh);
    logic [WposW-1:0] idx;
    idx = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (oh[i]) begin
        idx = idx | WposW'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/core/bpwm_if.sv */
// ----------------------------------------------------------------------------
// bpwm_if
// Valid/ready channels: input items and result items.
// ----------------------------------------------------------------------------
interface bpwm_in_if;
  import bpwm_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [DutyW-1:0] duty_byte;

  modport source (output valid, output op, output duty_byte, input ready);
  modport sink   (input valid, input op, input duty_byte, output ready);
endinterface

interface bpwm_out_if;
  import bpwm_pkg::*;

  logic               valid;
  logic               ready;
  logic [ChanOnW-1:0] channel_on;
  logic [WposW-1:0]   write_position;

  modport source (output valid, output channel_on, output write_position, input ready);
  modport sink   (input valid, input channel_on, input write_position, output ready);
endinterface

/* rtl/core/byte_loaded_multichannel_pwm.sv */
// ----------------------------------------------------------------------------
// byte_loaded_multichannel_pwm
// Multichannel PWM: a row of channel cells sharing one counter, with duty
// bytes loaded round-robin by a token passed along the row.
// ----------------------------------------------------------------------------
// Result items come from one output register, loaded when an item is accepted.
// Throughput: 1 item per cycle while the output side is ready; every cell compares
//   its next duty against the next counter value in the accepting cycle.
// Reset: asynchronous, active low; counter and timeout clear,
//   duties load the power-up table, timeout register reloads to 200.
module byte_loaded_multichannel_pwm import bpwm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_data_i,
  bpwm_in_if.sink             in_i,
  bpwm_out_if.source          out_o
);

  logic                accept;
  cell_ctrl_t          ctrl;
  logic [CHANNELS-1:0] token, token_next, cell_on;
  logic [ChanOnW-1:0]  chan_on;

  logic                out_valid_q;
  logic [ChanOnW-1:0]  channel_on_q;
  logic [WposW-1:0]    write_position_q;

  // Input side stays open while the output register drains or is empty
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  bpwm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .op_i        (in_i.op),
    .duty_byte_i (in_i.duty_byte),
    .ctrl_o      (ctrl)
  );

  // Chain of channel cells; last cell hands the token back to cell 0
  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    bpwm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .reset_duty_i  (DutyInit[g]),
      .reset_token_i (g == 0),
      .token_i       (token[(g + CHANNELS - 1) % CHANNELS]),
      .token_o       (token[g]),
      .token_next_o  (token_next[g]),
      .on_o          (cell_on[g])
    );
  end

  // Map cells onto the fixed-width output field
  for (genvar g = 0; g < ChanOnW; g++) begin : g_on
    if (g < CHANNELS) begin : g_live
      assign chan_on[g] = cell_on[g];
    end else begin : g_pad
      assign chan_on[g] = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      channel_on_q     <= chan_on;
      write_position_q <= onehot_to_index(token_next);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.channel_on     = channel_on_q;
  assign out_o.write_position = write_position_q;

endmodule

/* rtl/core/bpwm_cell.sv */
// ----------------------------------------------------------------------------
// bpwm_cell
// One PWM channel: holds its duty byte and the write token, passes the token
// to its neighbor on each loaded byte, and compares duty against the counter.
// ----------------------------------------------------------------------------
module bpwm_cell import bpwm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DutyW-1:0] reset_duty_i,  // tied constant per cell
  input  logic             reset_token_i, // high for cell 0 only
  input  logic             token_i,       // token from previous cell
  output logic             token_o,       // token held now, to next cell
  output logic             token_next_o,  // token after this item
  output logic             on_o           // channel output after this item
);

  logic [DutyW-1:0] duty_q, duty_d;
  logic             token_q, token_d;

  // Token holder takes the byte; token moves one cell on each byte
  always_comb begin
    duty_d  = duty_q;
    token_d = token_q;
    if (ctrl_i.load) begin
      if (token_q) begin
        duty_d = ctrl_i.duty_byte;
      end
      token_d = token_i;
    end else if (ctrl_i.resync) begin
      token_d = reset_token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= reset_duty_i;
      token_q <= reset_token_i;
    end else begin
      duty_q  <= duty_d;
      token_q <= token_d;
    end
  end

  assign token_o      = token_q;
  assign token_next_o = token_d;
  assign on_o         = duty_d > ctrl_i.count_next;

endmodule

/* rtl/core/bpwm_seq.sv */
// ----------------------------------------------------------------------------
// bpwm_seq
// Shared counter, resync timeout and the timeout register; drives the
// control broadcast for the cell chain.
// ----------------------------------------------------------------------------
module bpwm_seq import bpwm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic                op_i,
  input  logic [DutyW-1:0]    duty_byte_i,
  output cell_ctrl_t          ctrl_o
);

  logic [CountW-1:0]   count_q, count_d;
  logic [TimeoutW-1:0] timeout_q, timeout_d;
  logic [TimeoutW-1:0] resync_cfg_q;
  logic                resync;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resync_cfg_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      resync_cfg_q <= cfg_data_i;
    end
  end

  // Counter advance, timeout reload or countdown on wrap
  always_comb begin
    count_d   = count_q;
    timeout_d = timeout_q;
    resync    = 1'b0;
    if (accept_i) begin
      if (op_i == OpTick) begin
        count_d = count_q + CountW'(1);
        if (count_d == '0 && timeout_q != '0) begin
          timeout_d = timeout_q - TimeoutW'(1);
          resync    = (timeout_q == TimeoutW'(1));
        end
      end else begin
        timeout_d = resync_cfg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      timeout_q <= '0;
    end else begin
      count_q   <= count_d;
      timeout_q <= timeout_d;
    end
  end

  assign ctrl_o.load       = accept_i && (op_i == OpByte);
  assign ctrl_o.resync     = resync;
  assign ctrl_o.duty_byte  = duty_byte_i;
  assign ctrl_o.count_next = count_d;

endmodule
